@@ hdl/crcfr_pkg.sv @@
// ---------------------------------------------------------------------------
// crcfr_pkg: shared types and constants of the CRC frame receiver
// Result codes, register indexes, frame layout constants, the byte-wise
// CRC16-CCITT update and the command/status structs between controller
// and datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crcfr_pkg;

  // Payload store depth default
  localparam int MaxPayloadDef = 160;

  // Fixed part of a command payload: flags, 4 motors, 4 servos, text length
  localparam int CmdFixed = 14;
  // Text characters emitted at most (20 chunks of 8)
  localparam int TextMax  = 160;

  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'h1021;

  // Configuration register indexes
  localparam int CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgStartMarker = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgEndMarker   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCommandType = 2'd2;

  // Result status codes
  typedef enum logic [2:0] {
    RES_OK        = 3'd0,
    RES_UNHANDLED = 3'd1,
    RES_TOO_BIG   = 3'd2,
    RES_CRC_BAD   = 3'd3,
    RES_NO_END    = 3'd4,
    RES_TOO_SHORT = 3'd5
  } res_status_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic        hunt_init;   // start marker seen: restart crc and counters
    logic        hdr_take;    // header byte (type, length low, length high)
    logic        pay_take;    // payload byte
    logic        crc_take;    // crc byte
    logic        err_load;    // load an error result beat
    res_status_e err_code;
    logic        text_start;  // rewind the text reader
    logic        fetch;       // read one text byte into the next lane
    logic        push;        // load the assembled chunk as a result beat
  } crcfr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic start_hit;   // received byte equals start marker
    logic cnt_is0;
    logic cnt_is1;
    logic len_big;     // length completed by this byte exceeds the store
    logic len_zero;    // length completed by this byte is zero
    logic pay_done;    // this payload byte is the last one
    logic crc_ok;      // crc completed by this byte matches
    logic end_ok;      // received byte equals end marker
    logic cmd_type_hit; // frame type is the command type
    logic len_short;   // payload shorter than the fixed command part
    logic out_free;    // output register can take a beat this cycle
    logic lane_last;   // fetching the last lane of a chunk
    logic more_text;   // another chunk follows the current one
  } crcfr_stat_t;

  // CRC16-CCITT, MSB first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hdl/crcfr_rx_if.sv @@
// ---------------------------------------------------------------------------
// crcfr_rx_if: received byte channel
// Valid/ready channel carrying one link byte per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface crcfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ hdl/crcfr_res_if.sv @@
// ---------------------------------------------------------------------------
// crcfr_res_if: result channel
// Valid/ready channel carrying one frame result or text chunk per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface crcfr_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  frame_type;
  logic [7:0]  cmd_flags;
  logic [63:0] motor_words;
  logic [31:0] servo_bytes;
  logic [7:0]  txt_len;
  logic [63:0] text_chunk;
  logic        last;

  modport source (output valid, output status, output frame_type, output cmd_flags,
                  output motor_words, output servo_bytes, output txt_len,
                  output text_chunk, output last, input ready);
  modport sink   (input valid, input status, input frame_type, input cmd_flags,
                  input motor_words, input servo_bytes, input txt_len,
                  input text_chunk, input last, output ready);
endinterface

`default_nettype wire

@@ hdl/crc_frame_receiver.sv @@
// ---------------------------------------------------------------------------
// crc_frame_receiver: framed packet receiver with CRC16-CCITT check
// Parses start marker, type, length, payload, crc and end marker from a
// byte stream, reports frame errors and decodes command frames into
// result beats with text in 8-byte chunks.
// ---------------------------------------------------------------------------
//
//   Channel  Dir  Handshake     Beat contents
//   rx_i     in   valid/ready   rx_byte
//   res_o    out  valid/ready   status, frame_type, cmd_flags, motor_words,
//                               servo_bytes, txt_len, text_chunk, last
//   cfg      in   cfg_we_i      cfg_idx_i, cfg_data_i (write only)
//
// Received bytes are taken one per cycle while the output register has room.
// After the end marker of a good command frame the input is held while
// the text is read from the payload store one byte per cycle, each 8-byte
// chunk by 8 reads, one settle and one push (which waits for room), 1 to 20 chunks.
// A stalled result channel holds the input once a result is pending.
// Reset is immediate: the payload store needs no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crc_frame_receiver import crcfr_pkg::*; #(
  parameter int MaxPayload = MaxPayloadDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [7:0]         cfg_data_i,
  crcfr_rx_if.sink                rx_i,
  crcfr_res_if.source             res_o
);

  crcfr_cmd_t  cmd;
  crcfr_stat_t stat;
  logic        in_ready;

  assign rx_i.ready = in_ready;

  crcfr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (rx_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  crcfr_dp #(
    .MaxPayload (MaxPayload)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .rx_byte_i         (rx_i.rx_byte),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (res_o.valid),
    .out_ready_i       (res_o.ready),
    .out_status_o      (res_o.status),
    .out_frame_type_o  (res_o.frame_type),
    .out_cmd_flags_o   (res_o.cmd_flags),
    .out_motor_words_o (res_o.motor_words),
    .out_servo_bytes_o (res_o.servo_bytes),
    .out_txt_len_o     (res_o.txt_len),
    .out_text_chunk_o  (res_o.text_chunk),
    .out_last_o        (res_o.last)
  );

endmodule

`default_nettype wire

@@ hdl/crcfr_dp.sv @@
// ---------------------------------------------------------------------------
// crcfr_dp: receiver datapath
// Configuration registers, running CRC, byte counter, payload store,
// command field capture, text chunk assembly and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crcfr_dp import crcfr_pkg::*; #(
  parameter int MaxPayload = MaxPayloadDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // configuration write port
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [7:0]         cfg_data_i,
  // received byte
  input  wire logic [7:0]         rx_byte_i,
  // controller link
  input  wire crcfr_cmd_t         cmd_i,
  output      crcfr_stat_t        stat_o,
  // result channel
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic [2:0]         out_status_o,
  output      logic [7:0]         out_frame_type_o,
  output      logic [7:0]         out_cmd_flags_o,
  output      logic [63:0]        out_motor_words_o,
  output      logic [31:0]        out_servo_bytes_o,
  output      logic [7:0]         out_txt_len_o,
  output      logic [63:0]        out_text_chunk_o,
  output      logic               out_last_o
);

  localparam int AddrW = $clog2(MaxPayload);
  localparam int CntW  = $clog2(MaxPayload + 1);

  // configuration
  logic [7:0] start_marker_q, end_marker_q, command_type_q;

  // frame state
  logic [7:0]      type_q;
  logic [15:0]     len_q;
  logic [CntW-1:0] cnt_q;
  logic [15:0]     crc_q;
  logic [7:0]      crc_lo_q;

  // captured command fields
  logic [7:0]  flags_q;
  logic [63:0] motors_q;
  logic [31:0] servos_q;
  logic [7:0]  tlen_q;

  // text reader
  logic [7:0] pos_q;
  logic [2:0] lane_q;
  logic       place_q;
  logic       hit_q;
  logic [2:0] place_lane_q;
  logic [7:0] rdata_q;
  logic [7:0] chunk_q [8];

  // payload store
  logic [7:0] mem [MaxPayload];

  // output register
  logic        out_valid_q;
  logic [2:0]  o_status_q;
  logic [7:0]  o_type_q, o_flags_q, o_tlen_q;
  logic [63:0] o_motors_q, o_chunk_q;
  logic [31:0] o_servos_q;
  logic        o_last_q;

  logic [15:0]      len_full;
  logic [15:0]      cnt_next16;
  logic [15:0]      text_end16;
  logic [15:0]      rd_addr16;
  logic             rd_hit;
  logic             out_free;
  logic             wr_ok;
  logic [63:0]      chunk_flat;

  // Combine the byte under test with stored state
  assign len_full   = {rx_byte_i, len_q[7:0]};
  assign cnt_next16 = 16'(cnt_q) + 16'd1;
  assign text_end16 = 16'(CmdFixed) + 16'(rx_byte_i);
  assign rd_addr16  = 16'(CmdFixed) + 16'(pos_q);
  assign rd_hit     = (pos_q < tlen_q);
  assign out_free   = !out_valid_q || out_ready_i;
  assign wr_ok      = (16'(cnt_q) < 16'(MaxPayload));

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chunk_flat[8*i +: 8] = chunk_q[i];
    end
  end

  // Status toward the controller
  always_comb begin
    stat_o.start_hit    = (rx_byte_i == start_marker_q);
    stat_o.cnt_is0      = (cnt_q == '0);
    stat_o.cnt_is1      = (cnt_q == CntW'(1));
    stat_o.len_big      = (len_full > 16'(MaxPayload));
    stat_o.len_zero     = (len_full == 16'd0);
    stat_o.pay_done     = (cnt_next16 >= len_q);
    stat_o.crc_ok       = ({rx_byte_i, crc_lo_q} == crc_q);
    stat_o.end_ok       = (rx_byte_i == end_marker_q);
    stat_o.cmd_type_hit = (type_q == command_type_q);
    stat_o.len_short    = (len_q < 16'(CmdFixed));
    stat_o.out_free     = out_free;
    stat_o.lane_last    = (lane_q == 3'd7);
    stat_o.more_text    = (pos_q < tlen_q) && (pos_q < 8'(TextMax));
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= '0;
      end_marker_q   <= '0;
      command_type_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStartMarker: start_marker_q <= cfg_data_i;
        CfgEndMarker:   end_marker_q   <= cfg_data_i;
        CfgCommandType: command_type_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Frame state: crc, counter, header fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q   <= '0;
      len_q    <= '0;
      cnt_q    <= '0;
      crc_q    <= CrcInit;
      crc_lo_q <= '0;
    end else begin
      if (cmd_i.hunt_init) begin
        cnt_q <= '0;
        len_q <= '0;
        crc_q <= CrcInit;
      end
      if (cmd_i.hdr_take) begin
        crc_q <= crc16_byte(crc_q, rx_byte_i);
        if (cnt_q == '0) begin
          type_q <= rx_byte_i;
          cnt_q  <= CntW'(1);
        end else if (cnt_q == CntW'(1)) begin
          len_q <= {8'h00, rx_byte_i};
          cnt_q <= CntW'(2);
        end else begin
          len_q <= len_full;
          cnt_q <= '0;
        end
      end
      if (cmd_i.pay_take) begin
        crc_q <= crc16_byte(crc_q, rx_byte_i);
        if (cnt_next16 >= len_q) begin
          cnt_q <= '0;
        end else begin
          cnt_q <= cnt_q + CntW'(1);
        end
      end
      if (cmd_i.crc_take) begin
        if (cnt_q == '0) begin
          crc_lo_q <= rx_byte_i;
          cnt_q    <= CntW'(1);
        end else begin
          cnt_q <= '0;
        end
      end
    end
  end

  // Capture the fixed command fields as the payload streams in
  always_ff @(posedge clk_i) begin
    if (cmd_i.pay_take) begin
      if (cnt_q == '0) begin
        flags_q <= rx_byte_i;
      end
      for (int i = 0; i < 8; i++) begin
        if (cnt_q == CntW'(i + 1)) begin
          motors_q[8*i +: 8] <= rx_byte_i;
        end
      end
      for (int i = 0; i < 4; i++) begin
        if (cnt_q == CntW'(i + 9)) begin
          servos_q[8*i +: 8] <= rx_byte_i;
        end
      end
      // drop a text length that overruns the payload
      if (cnt_q == CntW'(CmdFixed - 1)) begin
        tlen_q <= (text_end16 > len_q) ? 8'd0 : rx_byte_i;
      end
    end
  end

  // Payload store: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.pay_take && wr_ok) begin
      mem[cnt_q[AddrW-1:0]] <= rx_byte_i;
    end
    if (cmd_i.fetch && rd_hit) begin
      rdata_q <= mem[rd_addr16[AddrW-1:0]];
    end
  end

  // Text reader control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      lane_q       <= '0;
      place_q      <= 1'b0;
      hit_q        <= 1'b0;
      place_lane_q <= '0;
    end else begin
      place_q <= cmd_i.fetch;
      if (cmd_i.text_start) begin
        pos_q  <= '0;
        lane_q <= '0;
      end else if (cmd_i.fetch) begin
        pos_q        <= pos_q + 8'd1;
        lane_q       <= lane_q + 3'd1;
        hit_q        <= rd_hit;
        place_lane_q <= lane_q;
      end
    end
  end

  // Place the fetched byte, or zero past the text end
  always_ff @(posedge clk_i) begin
    if (place_q) begin
      chunk_q[place_lane_q] <= hit_q ? rdata_q : 8'h00;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.err_load || cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.err_load) begin
      o_status_q <= cmd_i.err_code;
      o_type_q   <= type_q;
      o_flags_q  <= '0;
      o_motors_q <= '0;
      o_servos_q <= '0;
      o_tlen_q   <= '0;
      o_chunk_q  <= '0;
      o_last_q   <= 1'b1;
    end else if (cmd_i.push) begin
      o_status_q <= RES_OK;
      o_type_q   <= type_q;
      o_flags_q  <= flags_q;
      o_motors_q <= motors_q;
      o_servos_q <= servos_q;
      o_tlen_q   <= tlen_q;
      o_chunk_q  <= chunk_flat;
      o_last_q   <= !stat_o.more_text;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = o_status_q;
  assign out_frame_type_o  = o_type_q;
  assign out_cmd_flags_o   = o_flags_q;
  assign out_motor_words_o = o_motors_q;
  assign out_servo_bytes_o = o_servos_q;
  assign out_txt_len_o     = o_tlen_q;
  assign out_text_chunk_o  = o_chunk_q;
  assign out_last_o        = o_last_q;

endmodule

`default_nettype wire

@@ hdl/crcfr_ctrl.sv @@
// ---------------------------------------------------------------------------
// crcfr_ctrl: receiver controller
// Frame phase state machine (hunt, header, payload, crc, end) and the
// text chunk sequencer that runs after a good command frame.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module crcfr_ctrl import crcfr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire crcfr_stat_t stat_i,
  output      crcfr_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_HUNT,
    S_HEADER,
    S_PAYLOAD,
    S_CRC,
    S_END,
    S_FETCH,
    S_DRAIN,
    S_PUSH
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  // Take bytes only in the receive phases and with room for a result
  assign in_ready_o = (state_q inside {S_HUNT, S_HEADER, S_PAYLOAD, S_CRC, S_END})
                      && stat_i.out_free;
  assign acc = in_valid_i && in_ready_o;

  // Next state and datapath commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.err_code = RES_OK;
    case (state_q)
      S_HUNT: begin
        if (acc && stat_i.start_hit) begin
          cmd_o.hunt_init = 1'b1;
          state_d = S_HEADER;
        end
      end
      S_HEADER: begin
        if (acc) begin
          cmd_o.hdr_take = 1'b1;
          if (!stat_i.cnt_is0 && !stat_i.cnt_is1) begin
            if (stat_i.len_big) begin
              cmd_o.err_load = 1'b1;
              cmd_o.err_code = RES_TOO_BIG;
              state_d = S_HUNT;
            end else if (stat_i.len_zero) begin
              state_d = S_CRC;
            end else begin
              state_d = S_PAYLOAD;
            end
          end
        end
      end
      S_PAYLOAD: begin
        if (acc) begin
          cmd_o.pay_take = 1'b1;
          if (stat_i.pay_done) begin
            state_d = S_CRC;
          end
        end
      end
      S_CRC: begin
        if (acc) begin
          cmd_o.crc_take = 1'b1;
          if (!stat_i.cnt_is0) begin
            if (stat_i.crc_ok) begin
              state_d = S_END;
            end else begin
              cmd_o.err_load = 1'b1;
              cmd_o.err_code = RES_CRC_BAD;
              state_d = S_HUNT;
            end
          end
        end
      end
      S_END: begin
        if (acc) begin
          state_d = S_HUNT;
          if (!stat_i.end_ok) begin
            cmd_o.err_load = 1'b1;
            cmd_o.err_code = RES_NO_END;
          end else if (!stat_i.cmd_type_hit) begin
            cmd_o.err_load = 1'b1;
            cmd_o.err_code = RES_UNHANDLED;
          end else if (stat_i.len_short) begin
            cmd_o.err_load = 1'b1;
            cmd_o.err_code = RES_TOO_SHORT;
          end else begin
            cmd_o.text_start = 1'b1;
            state_d = S_FETCH;
          end
        end
      end
      // read eight text bytes, one lane per cycle
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        if (stat_i.lane_last) begin
          state_d = S_DRAIN;
        end
      end
      // last lane lands in the chunk
      S_DRAIN: begin
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d = stat_i.more_text ? S_FETCH : S_HUNT;
        end
      end
      default: begin
        state_d = S_HUNT;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire
